// ===== design/i2cbm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C bit-level master package
// Shared types, codes and the phase table of the simple commands.
// ----------------------------------------------------------------------------
package i2cbm_pkg;

  localparam int DLY_W       = 16;
  localparam int IN_DATA_W   = 16;
  localparam int IN_USER_W   = 3;
  localparam int OUT_DATA_W  = 16;
  localparam logic [DLY_W-1:0] DLY_RESET = DLY_W'(60);

  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_START = 3'd1,
    ACT_STOP  = 3'd2,
    ACT_ACK   = 3'd3,
    ACT_NACK  = 3'd4,
    ACT_WRITE = 3'd5,
    ACT_READ  = 3'd6
  } action_t;

  typedef enum logic [1:0] {
    OP_SCL_LO = 2'd0,
    OP_SCL_HI = 2'd1,
    OP_SDA_LO = 2'd2,
    OP_SDA_HI = 2'd3
  } pin_op_t;

  typedef struct packed {
    logic       is_cmd;
    action_t    action;
    logic [7:0] write_byte;
    logic       sda_in;
  } tick_t;

  localparam pin_op_t SIMPLE_OPS [4][5] = '{
    '{OP_SCL_LO, OP_SDA_HI, OP_SCL_HI, OP_SDA_LO, OP_SCL_LO},
    '{OP_SCL_LO, OP_SDA_LO, OP_SCL_HI, OP_SDA_HI, OP_SCL_LO},
    '{OP_SCL_LO, OP_SDA_LO, OP_SCL_HI, OP_SCL_LO, OP_SCL_LO},
    '{OP_SCL_LO, OP_SDA_HI, OP_SCL_HI, OP_SCL_LO, OP_SCL_LO}
  };

  function automatic pin_op_t simple_op(input logic [1:0] cmd_idx, input logic [2:0] ph);
    pin_op_t op;
    op = OP_SCL_LO;
    if (ph < 3'd5) begin
      op = SIMPLE_OPS[cmd_idx][ph];
    end
    return op;
  endfunction

  function automatic logic [2:0] simple_len(input logic [1:0] cmd_idx);
    return cmd_idx[1] ? 3'd4 : 3'd5;
  endfunction

endpackage

// ===== design/i2c_bit_level_master_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C bit-level master unit
// Each input transaction is one tick of an I2C master sequencer that plays
// start, stop, ACK, NACK, byte write and byte read phase sequences on SCL/SDA.
//
// Input channel: in_tuser carries the action, in_tdata the byte to write and
// the sampled SDA level. Result channel: one transaction per input tick with
// pin drive levels, busy and done flags, the last read byte, the last ACK bit
// and the reject flag. cfg_wr_en/cfg_wr_data set the phase hold in ticks.
//
// Throughput is one tick per cycle while the receiver accepts: the front
// end pushes into a two-entry queue and the sequencer pops one entry per
// cycle into its output register, where each result becomes valid.
// When the receiver stalls, the output register holds, the queue fills and
// in_tready drops after at most two more transactions. Reset empties the
// queue and output, releases both pins and sets the phase hold to 60 ticks.
// ----------------------------------------------------------------------------
module i2c_bit_level_master_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [i2cbm_pkg::DLY_W-1:0]       cfg_wr_data,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [7:0] write_byte, [8] sda_in, [15:9] zero
  input  logic [i2cbm_pkg::IN_DATA_W-1:0]   in_tdata,
  // [2:0] action
  input  logic [i2cbm_pkg::IN_USER_W-1:0]   in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [0] scl_out, [1] sda_out, [2] busy_res, [3] done_res, [11:4] read_byte,
  // [12] ack_bit, [13] rejected, [15:14] zero
  output logic [i2cbm_pkg::OUT_DATA_W-1:0]  out_tdata
);

  logic             q_full;
  logic             q_push;
  logic             q_pop;
  logic             q_not_empty;
  i2cbm_pkg::tick_t q_entry;
  i2cbm_pkg::tick_t q_head;

  i2cbm_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_entry)
  );

  i2cbm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  i2cbm_engine u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

endmodule

// ===== design/i2cbm_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C bit-level master front end
// Unpacks incoming ticks, marks which carry a valid command, feeds the queue.
// ----------------------------------------------------------------------------
module i2cbm_front (
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [i2cbm_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic [i2cbm_pkg::IN_USER_W-1:0]   in_tuser,
  input  logic                              q_full,
  output logic                              q_push,
  output i2cbm_pkg::tick_t                  q_entry
);

  i2cbm_pkg::action_t act;

  always_comb begin
    act = i2cbm_pkg::action_t'(in_tuser);
    q_entry.action     = act;
    q_entry.write_byte = in_tdata[7:0];
    q_entry.sda_in     = in_tdata[8];
    unique case (act)
      i2cbm_pkg::ACT_START, i2cbm_pkg::ACT_STOP, i2cbm_pkg::ACT_ACK,
      i2cbm_pkg::ACT_NACK, i2cbm_pkg::ACT_WRITE, i2cbm_pkg::ACT_READ: begin
        q_entry.is_cmd = 1'b1;
      end
      default: begin
        q_entry.is_cmd = 1'b0;
      end
    endcase
  end

  assign in_tready = ~q_full;
  assign q_push    = in_tvalid & ~q_full;

endmodule

// ===== design/i2cbm_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C bit-level master tick queue
// Two-entry queue between the front end and the sequencer.
// ----------------------------------------------------------------------------
module i2cbm_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  i2cbm_pkg::tick_t  push_entry,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output i2cbm_pkg::tick_t  head
);

  i2cbm_pkg::tick_t mem_r [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] count_r;
  logic [1:0] count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  assign full      = count_r[1];
  assign not_empty = count_r != 2'd0;
  assign head      = mem_r[rd_ptr_r];

endmodule

// ===== design/i2cbm_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C bit-level master sequencer
// Plays the SCL/SDA phase sequences one tick per queue entry, with an
// output register toward the result channel.
// ----------------------------------------------------------------------------
module i2cbm_engine (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [i2cbm_pkg::DLY_W-1:0]       cfg_wr_data,
  input  logic                              q_not_empty,
  input  i2cbm_pkg::tick_t                  q_head,
  output logic                              q_pop,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [i2cbm_pkg::OUT_DATA_W-1:0]  out_tdata
);

  localparam logic [5:0] STEP_IDLE  = 6'd0;
  localparam logic [5:0] STEP_FIRST = 6'd1;
  localparam logic [5:0] STEP_END   = 6'd63;
  localparam logic [5:0] W_DATA     = 6'd1;
  localparam logic [5:0] W_CLKH     = 6'd2;
  localparam logic [5:0] W_CLKL     = 6'd3;
  localparam logic [5:0] W_ACK_REL  = 6'd4;
  localparam logic [5:0] W_ACK_CLKH = 6'd5;
  localparam logic [5:0] W_ACK_SMP  = 6'd6;
  localparam logic [5:0] R_REL      = 6'd1;
  localparam logic [5:0] R_CLKH     = 6'd2;
  localparam logic [5:0] R_SMP      = 6'd3;
  localparam logic [5:0] R_CLKL     = 6'd4;
  localparam logic [5:0] R_GAP      = 6'd5;

  logic [i2cbm_pkg::DLY_W-1:0] phase_delay_r;
  logic [5:0]                  step_r, step_nxt;
  i2cbm_pkg::action_t          cmd_r, cmd_nxt;
  logic [i2cbm_pkg::DLY_W-1:0] dly_r, dly_nxt;
  logic [3:0]                  bit_r, bit_nxt;
  logic [7:0]                  shift_r, shift_nxt;
  logic                        scl_r, scl_nxt;
  logic                        sda_r, sda_nxt;
  logic                        ack_r, ack_nxt;
  logic [7:0]                  rx_r, rx_nxt;
  logic                        out_valid_r;
  logic [i2cbm_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic               done_c, rej_c, run, hold;
  logic [5:0]         s;
  i2cbm_pkg::action_t c;
  logic [7:0]         sh;
  logic [3:0]         bc_inc;
  logic [1:0]         cidx;
  logic [2:0]         len;
  i2cbm_pkg::pin_op_t op;

  assign q_pop = q_not_empty & (~out_valid_r | out_tready);

  always_comb begin
    step_nxt  = step_r;
    cmd_nxt   = cmd_r;
    dly_nxt   = dly_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    ack_nxt   = ack_r;
    rx_nxt    = rx_r;
    done_c    = 1'b0;
    rej_c     = 1'b0;
    run       = 1'b0;
    hold      = 1'b1;
    s         = step_r;
    c         = cmd_r;
    sh        = shift_r;
    bc_inc    = bit_r + 4'd1;
    cidx      = 2'd0;
    len       = 3'd0;
    op        = i2cbm_pkg::OP_SCL_LO;

    if (q_pop) begin
      if (step_r == STEP_IDLE) begin
        if (q_head.is_cmd) begin
          cmd_nxt   = q_head.action;
          bit_nxt   = 4'd0;
          shift_nxt = (q_head.action == i2cbm_pkg::ACT_WRITE) ? q_head.write_byte : 8'd0;
          c         = q_head.action;
          sh        = shift_nxt;
          bc_inc    = 4'd1;
          s         = STEP_FIRST;
          run       = 1'b1;
        end
      end else begin
        rej_c = q_head.is_cmd;
        if (dly_r != '0) begin
          dly_nxt = dly_r - i2cbm_pkg::DLY_W'(1);
        end else begin
          run = 1'b1;
        end
      end
    end

    if (run) begin
      if (s == STEP_END) begin
        step_nxt = STEP_IDLE;
        dly_nxt  = '0;
        done_c   = 1'b1;
        if (c == i2cbm_pkg::ACT_READ) begin
          rx_nxt = sh;
        end
      end else begin
        unique case (c)
          i2cbm_pkg::ACT_START, i2cbm_pkg::ACT_STOP,
          i2cbm_pkg::ACT_ACK, i2cbm_pkg::ACT_NACK: begin
            cidx = 2'(c - 3'd1);
            len  = i2cbm_pkg::simple_len(cidx);
            if (s >= STEP_FIRST && s <= {3'b000, len}) begin
              op = i2cbm_pkg::simple_op(cidx, 3'(s - 6'd1));
              unique case (op)
                i2cbm_pkg::OP_SCL_LO: scl_nxt = 1'b0;
                i2cbm_pkg::OP_SCL_HI: scl_nxt = 1'b1;
                i2cbm_pkg::OP_SDA_LO: sda_nxt = 1'b0;
                i2cbm_pkg::OP_SDA_HI: sda_nxt = 1'b1;
              endcase
              step_nxt = (s == {3'b000, len}) ? STEP_END : 6'(s + 6'd1);
            end else begin
              step_nxt = STEP_END;
            end
          end
          i2cbm_pkg::ACT_WRITE: begin
            unique case (s)
              W_DATA: begin
                sda_nxt  = sh[7];
                step_nxt = W_CLKH;
              end
              W_CLKH: begin
                scl_nxt  = 1'b1;
                step_nxt = W_CLKL;
              end
              W_CLKL: begin
                scl_nxt   = 1'b0;
                shift_nxt = {sh[6:0], 1'b0};
                bit_nxt   = bc_inc;
                hold      = 1'b0;
                step_nxt  = (bc_inc < 4'd8) ? W_DATA : W_ACK_REL;
              end
              W_ACK_REL: begin
                sda_nxt  = 1'b1;
                step_nxt = W_ACK_CLKH;
              end
              W_ACK_CLKH: begin
                scl_nxt  = 1'b1;
                step_nxt = W_ACK_SMP;
              end
              W_ACK_SMP: begin
                ack_nxt  = q_head.sda_in;
                step_nxt = 6'd7;
              end
              default: begin
                scl_nxt  = 1'b0;
                step_nxt = STEP_END;
              end
            endcase
          end
          i2cbm_pkg::ACT_READ: begin
            unique case (s)
              R_REL: begin
                sda_nxt  = 1'b1;
                step_nxt = R_CLKH;
              end
              R_CLKH: begin
                scl_nxt  = 1'b1;
                hold     = 1'b0;
                step_nxt = R_SMP;
              end
              R_SMP: begin
                shift_nxt = {sh[6:0], q_head.sda_in};
                step_nxt  = R_CLKL;
              end
              R_CLKL: begin
                scl_nxt  = 1'b0;
                bit_nxt  = bc_inc;
                step_nxt = (bc_inc < 4'd8) ? R_GAP : STEP_END;
              end
              default: begin
                step_nxt = R_CLKH;
              end
            endcase
          end
          default: begin
            step_nxt = STEP_END;
            hold     = 1'b0;
          end
        endcase
        dly_nxt = hold ? phase_delay_r : '0;
      end
    end

    out_data_nxt = {2'b00, rej_c, ack_nxt, rx_nxt, done_c, (step_nxt != STEP_IDLE),
                    sda_nxt, scl_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_delay_r <= i2cbm_pkg::DLY_RESET;
      step_r        <= STEP_IDLE;
      cmd_r         <= i2cbm_pkg::ACT_NONE;
      dly_r         <= '0;
      bit_r         <= 4'd0;
      shift_r       <= 8'd0;
      scl_r         <= 1'b1;
      sda_r         <= 1'b1;
      ack_r         <= 1'b1;
      rx_r          <= 8'd0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        phase_delay_r <= cfg_wr_data;
      end
      step_r  <= step_nxt;
      cmd_r   <= cmd_nxt;
      dly_r   <= dly_nxt;
      bit_r   <= bit_nxt;
      shift_r <= shift_nxt;
      scl_r   <= scl_nxt;
      sda_r   <= sda_nxt;
      ack_r   <= ack_nxt;
      rx_r    <= rx_nxt;
      if (q_pop) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && done_c) |=> (step_r == STEP_IDLE))
    else $error("sequence completion did not return to idle");

  a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && rej_c) |-> (step_r != STEP_IDLE))
    else $error("command rejected while idle");

  a_idle_no_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == STEP_IDLE) |-> (dly_r == '0))
    else $error("hold count pending while idle");

  a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_r <= 4'd8)
    else $error("bit count beyond one byte");

endmodule

// ===== tb/i2c_bit_level_master_unit_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C bit-level master unit checker
// Watches the input, result and configuration ports, runs its own model of
// the SCL/SDA sequencer on every accepted tick and compares each accepted
// result, field by field, with the oldest predicted pin state.
// ----------------------------------------------------------------------------
module i2c_bit_level_master_unit_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [i2cbm_pkg::DLY_W-1:0]       cfg_wr_data,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  input  logic [i2cbm_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic [i2cbm_pkg::IN_USER_W-1:0]   in_tuser,
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic [i2cbm_pkg::OUT_DATA_W-1:0]  out_tdata,
  output int                                mismatch_count,
  output int                                pending_count
);

  localparam logic [5:0] STEP_IDLE = 6'd0;
  localparam logic [5:0] STEP_END  = 6'd63;

  localparam i2cbm_pkg::pin_op_t PHASE_PLAN [4][5] = '{
    '{i2cbm_pkg::OP_SCL_LO, i2cbm_pkg::OP_SDA_HI, i2cbm_pkg::OP_SCL_HI,
      i2cbm_pkg::OP_SDA_LO, i2cbm_pkg::OP_SCL_LO},
    '{i2cbm_pkg::OP_SCL_LO, i2cbm_pkg::OP_SDA_LO, i2cbm_pkg::OP_SCL_HI,
      i2cbm_pkg::OP_SDA_HI, i2cbm_pkg::OP_SCL_LO},
    '{i2cbm_pkg::OP_SCL_LO, i2cbm_pkg::OP_SDA_LO, i2cbm_pkg::OP_SCL_HI,
      i2cbm_pkg::OP_SCL_LO, i2cbm_pkg::OP_SCL_LO},
    '{i2cbm_pkg::OP_SCL_LO, i2cbm_pkg::OP_SDA_HI, i2cbm_pkg::OP_SCL_HI,
      i2cbm_pkg::OP_SCL_LO, i2cbm_pkg::OP_SCL_LO}
  };

  typedef struct packed {
    logic [1:0] pad;
    logic       rejected;
    logic       ack_bit;
    logic [7:0] read_byte;
    logic       done;
    logic       busy;
    logic       sda;
    logic       scl;
  } pin_state_t;

  logic [i2cbm_pkg::DLY_W-1:0] hold_ticks;
  logic [5:0]                  step;
  i2cbm_pkg::action_t          cmd;
  logic [i2cbm_pkg::DLY_W-1:0] hold_cnt;
  logic [3:0]                  nbits;
  logic [7:0]                  shreg;
  logic                        scl_lvl;
  logic                        sda_lvl;
  logic                        ack_lvl;
  logic [7:0]                  rx_byte;

  pin_state_t expected_pin_states [$];

  // Plays the current phase of the running command; returns 1 on completion.
  function automatic logic advance_phase(input logic sda);
    logic               hold;
    int                 c;
    int                 len;
    i2cbm_pkg::pin_op_t op;
    hold = 1'b1;
    if (step == STEP_END) begin
      step = STEP_IDLE;
      hold_cnt = '0;
      if (cmd == i2cbm_pkg::ACT_READ) begin
        rx_byte = shreg;
      end
      return 1'b1;
    end
    case (cmd)
      i2cbm_pkg::ACT_START, i2cbm_pkg::ACT_STOP,
      i2cbm_pkg::ACT_ACK, i2cbm_pkg::ACT_NACK: begin
        c = int'(cmd) - int'(i2cbm_pkg::ACT_START);
        len = (c < 2) ? 5 : 4;
        if (step >= 6'd1 && int'(step) <= len) begin
          op = PHASE_PLAN[c][step - 6'd1];
          case (op)
            i2cbm_pkg::OP_SCL_LO: scl_lvl = 1'b0;
            i2cbm_pkg::OP_SCL_HI: scl_lvl = 1'b1;
            i2cbm_pkg::OP_SDA_LO: sda_lvl = 1'b0;
            default:              sda_lvl = 1'b1;
          endcase
          step = (int'(step) == len) ? STEP_END : step + 6'd1;
        end else begin
          step = STEP_END;
        end
      end
      i2cbm_pkg::ACT_WRITE: begin
        case (step)
          6'd1: begin
            sda_lvl = shreg[7];
            step = 6'd2;
          end
          6'd2: begin
            scl_lvl = 1'b1;
            step = 6'd3;
          end
          6'd3: begin
            scl_lvl = 1'b0;
            shreg = {shreg[6:0], 1'b0};
            nbits = nbits + 4'd1;
            hold = 1'b0;
            step = (nbits < 4'd8) ? 6'd1 : 6'd4;
          end
          6'd4: begin
            sda_lvl = 1'b1;
            step = 6'd5;
          end
          6'd5: begin
            scl_lvl = 1'b1;
            step = 6'd6;
          end
          6'd6: begin
            ack_lvl = sda;
            step = 6'd7;
          end
          default: begin
            scl_lvl = 1'b0;
            step = STEP_END;
          end
        endcase
      end
      i2cbm_pkg::ACT_READ: begin
        case (step)
          6'd1: begin
            sda_lvl = 1'b1;
            step = 6'd2;
          end
          6'd2: begin
            scl_lvl = 1'b1;
            hold = 1'b0;
            step = 6'd3;
          end
          6'd3: begin
            shreg = {shreg[6:0], sda};
            step = 6'd4;
          end
          6'd4: begin
            scl_lvl = 1'b0;
            nbits = nbits + 4'd1;
            step = (nbits < 4'd8) ? 6'd5 : STEP_END;
          end
          default: step = 6'd2;
        endcase
      end
      default: begin
        step = STEP_END;
        hold = 1'b0;
      end
    endcase
    hold_cnt = hold ? hold_ticks : '0;
    return 1'b0;
  endfunction

  function automatic pin_state_t sequencer_tick(input logic [2:0] act, input logic [7:0] wbyte,
                                                input logic sda);
    pin_state_t r;
    logic       is_cmd;
    logic       done;
    logic       rej;
    is_cmd = (act >= i2cbm_pkg::ACT_START) && (act <= i2cbm_pkg::ACT_READ);
    done = 1'b0;
    rej = 1'b0;
    if (step == STEP_IDLE) begin
      if (is_cmd) begin
        cmd = i2cbm_pkg::action_t'(act);
        nbits = '0;
        shreg = (act == i2cbm_pkg::ACT_WRITE) ? wbyte : 8'h00;
        step = 6'd1;
        done = advance_phase(sda);
      end
    end else begin
      rej = is_cmd;
      if (hold_cnt != '0) begin
        hold_cnt = hold_cnt - i2cbm_pkg::DLY_W'(1);
      end else begin
        done = advance_phase(sda);
      end
    end
    r = '0;
    r.scl = scl_lvl;
    r.sda = sda_lvl;
    r.busy = (step != STEP_IDLE);
    r.done = done;
    r.read_byte = rx_byte;
    r.ack_bit = ack_lvl;
    r.rejected = rej;
    return r;
  endfunction

  function automatic void compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    pin_state_t want;
    pin_state_t got;
    if (!rst_n) begin
      hold_ticks = i2cbm_pkg::DLY_RESET;
      step = STEP_IDLE;
      cmd = i2cbm_pkg::ACT_NONE;
      hold_cnt = '0;
      nbits = '0;
      shreg = '0;
      scl_lvl = 1'b1;
      sda_lvl = 1'b1;
      ack_lvl = 1'b1;
      rx_byte = '0;
      mismatch_count = 0;
      expected_pin_states.delete();
    end else begin
      if (cfg_wr_en) begin
        hold_ticks = cfg_wr_data;
      end
      if (in_tvalid && in_tready) begin
        expected_pin_states.push_back(sequencer_tick(in_tuser, in_tdata[7:0], in_tdata[8]));
      end
      if (out_tvalid && out_tready) begin
        got = pin_state_t'(out_tdata);
        if (expected_pin_states.size() == 0) begin
          $display("%0t: result with no prediction pending, expected none, actual %h",
                   $time, out_tdata);
          mismatch_count++;
        end else begin
          want = expected_pin_states.pop_front();
          compare_field("scl_out", want.scl, got.scl);
          compare_field("sda_out", want.sda, got.sda);
          compare_field("busy", want.busy, got.busy);
          compare_field("done", want.done, got.done);
          compare_field("read_byte", want.read_byte, got.read_byte);
          compare_field("ack_bit", want.ack_bit, got.ack_bit);
          compare_field("rejected", want.rejected, got.rejected);
          compare_field("padding", want.pad, got.pad);
        end
      end
    end
    pending_count = expected_pin_states.size();
  end

endmodule

// ===== tb/i2c_bit_level_master_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C bit-level master unit testbench
// Drives sequencer ticks carrying start, stop, ACK, NACK, write and read
// commands through the input stream, with random gaps, receiver stalls and
// one long receiver hold-off, over several phase hold settings including
// zero, the reset value and the maximum. A separate checker predicts and
// compares every result transaction.
// ----------------------------------------------------------------------------
module i2c_bit_level_master_unit_test;

  localparam logic [2:0] ACT_UNDEF       = 3'd7;
  localparam int         SDA_LOW         = 0;
  localparam int         SDA_HIGH        = 1;
  localparam int         SDA_RANDOM      = 2;
  localparam int         BUSY_BIT        = 2;
  localparam int         STALL_LIMIT     = 2000;
  localparam int         HOLD_OFF_CYCLES = 300;
  localparam int         PHASE_ITEMS     = 180;
  localparam int         NOISE_PCT       = 5;
  localparam int         MAX_HOLD_TICKS  = 20;

  logic                             clk = 1'b0;
  logic                             rst_n;
  logic                             cfg_wr_en;
  logic [i2cbm_pkg::DLY_W-1:0]      cfg_wr_data;
  logic                             in_tvalid;
  logic                             in_tready;
  logic [i2cbm_pkg::IN_DATA_W-1:0]  in_tdata;
  logic [i2cbm_pkg::IN_USER_W-1:0]  in_tuser;
  logic                             out_tvalid;
  logic                             out_tready;
  logic [i2cbm_pkg::OUT_DATA_W-1:0] out_tdata;

  int   tx_count = 0;
  int   rx_count = 0;
  logic last_busy = 1'b0;
  int   idle_cycles = 0;
  bit   send_gaps_on = 1'b1;
  bit   recv_gaps_on = 1'b1;
  bit   hold_off_go = 1'b0;
  int   mismatch_count;
  int   pending_count;

  logic [i2cbm_pkg::DLY_W-1:0] random_delays [5] = '{16'd1, 16'd0, 16'd2, 16'd3, 16'd5};

  always #4 clk = ~clk;

  i2c_bit_level_master_unit i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  i2c_bit_level_master_unit_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      rx_count <= rx_count + 1;
      last_busy <= out_tdata[BUSY_BIT];
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : result_sink
    int  gap;
    bit  hold_done;
    hold_done = 1'b0;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      gap = recv_gaps_on ? $urandom_range(0, 10) : 0;
      if (hold_off_go && !hold_done) begin
        gap = HOLD_OFF_CYCLES;
        hold_done = 1'b1;
      end
      if (gap != 0) begin
        @(negedge clk) out_tready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk) out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  function automatic logic tick_sda(input int mode);
    return (mode == SDA_RANDOM) ? 1'($urandom) : mode[0];
  endfunction

  task automatic send_tick(input logic [2:0] act, input logic [7:0] wbyte, input logic sda);
    int gap;
    gap = send_gaps_on ? $urandom_range(0, 10) : 0;
    if (gap != 0) begin
      @(negedge clk) in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {7'b0, sda, wbyte};
    in_tuser <= act;
    do @(posedge clk); while (!in_tready);
    tx_count++;
  endtask

  task automatic wait_drained();
    @(negedge clk) in_tvalid <= 1'b0;
    while (rx_count != tx_count) @(negedge clk);
  endtask

  // Issues one command and keeps ticking until the engine reports idle.
  task automatic run_command(input logic [2:0] act, input logic [7:0] wbyte,
                             input int sda_mode, input int noise_pct);
    int         first;
    logic [2:0] a;
    send_tick(act, wbyte, tick_sda(sda_mode));
    first = tx_count;
    do begin
      while (rx_count < first || last_busy) begin
        a = ($urandom_range(1, 100) <= noise_pct) ? 3'($urandom_range(1, 7))
                                                   : i2cbm_pkg::ACT_NONE;
        send_tick(a, 8'($urandom), tick_sda(sda_mode));
      end
      wait_drained();
    end while (last_busy);
  endtask

  task automatic set_phase_delay(input logic [i2cbm_pkg::DLY_W-1:0] value);
    wait_drained();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk) cfg_wr_en <= 1'b0;
  endtask

  initial begin : stimulus
    int         phase_start;
    int         pick;
    logic [2:0] act;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // The reset value of the phase hold is used before any write.
    run_command(i2cbm_pkg::ACT_START, 8'h00, SDA_RANDOM, 0);

    set_phase_delay(16'd0);
    run_command(i2cbm_pkg::ACT_START, 8'h00, SDA_RANDOM, 0);
    run_command(i2cbm_pkg::ACT_WRITE, 8'h00, SDA_LOW, 0);
    run_command(i2cbm_pkg::ACT_WRITE, 8'hFF, SDA_HIGH, 0);
    run_command(i2cbm_pkg::ACT_WRITE, 8'hA5, SDA_RANDOM, 0);
    run_command(i2cbm_pkg::ACT_READ, 8'h00, SDA_HIGH, 0);
    run_command(i2cbm_pkg::ACT_READ, 8'hFF, SDA_LOW, 0);
    run_command(i2cbm_pkg::ACT_ACK, 8'h00, SDA_RANDOM, 0);
    run_command(i2cbm_pkg::ACT_NACK, 8'h00, SDA_RANDOM, 0);
    run_command(i2cbm_pkg::ACT_STOP, 8'h00, SDA_RANDOM, 0);
    run_command(ACT_UNDEF, 8'hFF, SDA_HIGH, 0);
    run_command(i2cbm_pkg::ACT_NONE, 8'h5A, SDA_LOW, 0);
    // With no hold, a start completes on its sixth tick; a stop lands there.
    send_tick(i2cbm_pkg::ACT_START, 8'h00, 1'b1);
    repeat (4) send_tick(i2cbm_pkg::ACT_NONE, 8'h00, 1'b1);
    send_tick(i2cbm_pkg::ACT_STOP, 8'h00, 1'b1);
    run_command(i2cbm_pkg::ACT_STOP, 8'h00, SDA_RANDOM, 0);
    run_command(i2cbm_pkg::ACT_READ, 8'h3C, SDA_RANDOM, 50);

    for (int p = 0; p < 5; p++) begin
      send_gaps_on = ($urandom_range(0, 3) != 0);
      recv_gaps_on = ($urandom_range(0, 3) != 0);
      set_phase_delay(random_delays[p]);
      if (p == 2) begin
        send_gaps_on = 1'b0;
        hold_off_go = 1'b1;
      end
      phase_start = tx_count;
      while (tx_count - phase_start < PHASE_ITEMS) begin
        pick = $urandom_range(0, 11);
        act = (pick == 0) ? i2cbm_pkg::ACT_NONE :
              (pick == 1) ? ACT_UNDEF : 3'($urandom_range(1, 6));
        run_command(act, 8'($urandom), SDA_RANDOM, NOISE_PCT);
      end
    end

    // The largest hold: the engine stays in the first phase for these ticks.
    send_gaps_on = 1'b0;
    recv_gaps_on = 1'b0;
    set_phase_delay(16'hFFFF);
    send_tick(i2cbm_pkg::ACT_ACK, 8'h00, 1'b0);
    repeat (MAX_HOLD_TICKS) send_tick(i2cbm_pkg::ACT_NONE, 8'h00, 1'b0);
    send_tick(i2cbm_pkg::ACT_STOP, 8'h00, 1'b0);

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
